[rtl/stq_pkg.sv]
// ---------------------------------------------------------------------------
// stq_pkg: shared types for the sorted alarm timer queue
// Alarm record, command and result codes, cell commands and serial time compare.
// ---------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

  localparam int TIME_W  = 32;
  localparam int DELAY_W = 16;
  localparam int TAG_W   = 16;

  // command codes on the input channel
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]  expiry;
    logic [DELAY_W-1:0] delay;
    logic [TAG_W-1:0]   tag;
  } alarm_t;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_FIRE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t op;
    alarm_t   new_alarm;
  } cell_ctl_t;

  // a at or before b: (b - a) read as two's complement is not negative
  function automatic logic at_or_before(input logic [TIME_W-1:0] a,
                                        input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] diff;
    diff = b - a;
    return ~diff[TIME_W-1];
  endfunction

endpackage

`default_nettype wire

[rtl/stq_ifs.sv]
// ---------------------------------------------------------------------------
// stq_ifs: channel interfaces of the sorted alarm timer queue
// Command channel and result channel, valid/ready with payload.
// ---------------------------------------------------------------------------
`default_nettype none

interface stq_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] delay_seconds;
  logic [15:0] tag_id;

  modport source (output valid, output cmd, output delay_seconds, output tag_id,
                  input ready);
  modport sink   (input valid, input cmd, input delay_seconds, input tag_id,
                  output ready);
endinterface

interface stq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] out_tag;
  logic [15:0] out_delay;
  logic [31:0] out_expiry;
  logic        last_result;

  modport source (output valid, output kind, output out_tag, output out_delay,
                  output out_expiry, output last_result, input ready);
  modport sink   (input valid, input kind, input out_tag, input out_delay,
                  input out_expiry, input last_result, output ready);
endinterface

`default_nettype wire

[rtl/stq_cell.sv]
// ---------------------------------------------------------------------------
// stq_cell: one slot of the sorted alarm chain
// Holds one alarm; on insert shifts from the left or takes the new alarm,
// on pop takes the alarm from the right.
// ---------------------------------------------------------------------------
`default_nettype none

module stq_cell
  import stq_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic      occupied,    // slot index below fill count
  input  wire logic      at_tail,     // slot index equals fill count
  input  wire logic      ahead_in,    // insert point lies left of this slot
  output logic           ahead_out,
  input  wire alarm_t    prev_alarm,
  input  wire alarm_t    next_alarm,
  output alarm_t         alarm
);

  alarm_t alarm_r;
  alarm_t alarm_nxt;
  logic   hit;

  assign hit       = occupied && at_or_before(ctl.new_alarm.expiry, alarm_r.expiry);
  assign ahead_out = ahead_in | hit;
  assign alarm     = alarm_r;

  always_comb begin
    alarm_nxt = alarm_r;
    case (ctl.op)
      CELL_INSERT: begin
        if (ahead_in) begin
          alarm_nxt = prev_alarm;
        end else if (hit || at_tail) begin
          alarm_nxt = ctl.new_alarm;
        end
      end
      CELL_POP: begin
        alarm_nxt = next_alarm;
      end
      default: begin
        alarm_nxt = alarm_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    alarm_r <= alarm_nxt;
  end

endmodule

`default_nettype wire

[rtl/sorted_alarm_timer_queue.sv]
// ---------------------------------------------------------------------------
// sorted_alarm_timer_queue: alarm timer queue on a chain of sorted cells
// Inserts alarms in expiry order, pops the head into a current slot on
// ticks and reports alarms as they fire.
// ---------------------------------------------------------------------------
//
//  channel   dir   word contents
//  --------  ----  ---------------------------------------------------------
//  in_ch     in    cmd (0 insert / 1 tick), delay_seconds, tag_id
//  out_ch    out   kind, out_tag, out_delay, out_expiry, last_result
//
//  Insert: latch, then a single compare-and-shift across all cells,
//  one result word.
//  Tick: latch, dispatch, then pops from the head cell and fires of due
//  alarms, closing with a final empty/not-due check.
//  Reset clears time, fill count and current slot; cell contents are
//  don't-care until written. A stalled out_ch holds the engine in place;
//  a new word is taken only after the previous one is fully processed.
//
`default_nettype none

module sorted_alarm_timer_queue
  import stq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  stq_in_if.sink    in_ch,
  stq_out_if.source out_ch
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STEP
  } state_t;

  state_t            state_r, state_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              cur_valid_r, cur_valid_nxt;
  alarm_t            cur_r, cur_nxt;
  logic              is_tick_r, is_tick_nxt;
  alarm_t            new_r, new_nxt;

  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  alarm_t            out_alarm_r, out_alarm_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_fire;
  logic              out_free;
  logic              full;
  logic              cur_due;
  logic              head_due;
  cell_ctl_t         ctl;

  // chain wiring: ahead[i] feeds cell i, ahead[i+1] leaves it
  logic   [QUEUE_DEPTH:0]   ahead;
  alarm_t [QUEUE_DEPTH-1:0] cell_alarm;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign full        = (count_r == CNT_W'(QUEUE_DEPTH));
  assign cur_due     = at_or_before(cur_r.expiry, now_r);
  // head of chain would be popped and fire right after the current alarm
  assign head_due    = at_or_before(cell_alarm[0].expiry, now_r);

  assign ahead[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      alarm_t prev_a;
      alarm_t next_a;
      if (gi == 0) begin : g_first
        assign prev_a = ctl.new_alarm;
      end else begin : g_mid
        assign prev_a = cell_alarm[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign next_a = cell_alarm[gi];
      end else begin : g_inner
        assign next_a = cell_alarm[gi+1];
      end

      stq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (count_r > CNT_W'(gi)),
        .at_tail    (count_r == CNT_W'(gi)),
        .ahead_in   (ahead[gi]),
        .ahead_out  (ahead[gi+1]),
        .prev_alarm (prev_a),
        .next_alarm (next_a),
        .alarm      (cell_alarm[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    count_nxt     = count_r;
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    is_tick_nxt   = is_tick_r;
    new_nxt       = new_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_alarm_nxt = out_alarm_r;
    out_last_nxt  = out_last_r;
    ctl.op        = CELL_HOLD;
    ctl.new_alarm = new_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          is_tick_nxt    = (in_ch.cmd == CMD_TICK);
          new_nxt.expiry = now_r + TIME_W'(in_ch.delay_seconds);
          new_nxt.delay  = in_ch.delay_seconds;
          new_nxt.tag    = in_ch.tag_id;
          if (in_ch.cmd == CMD_TICK) begin
            now_nxt = now_r + TIME_W'(1);
          end
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (is_tick_r) begin
          state_nxt = ST_STEP;
        end else if (out_free) begin
          // insert: compare against every cell and shift, all in this state
          if (!full) begin
            ctl.op    = CELL_INSERT;
            count_nxt = count_r + CNT_W'(1);
          end
          out_valid_nxt = 1'b1;
          out_kind_nxt  = full ? KIND_REJECT : KIND_ACCEPT;
          out_alarm_nxt = new_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_STEP: begin
        if (!cur_valid_r) begin
          if (count_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            ctl.op        = CELL_POP;
            cur_nxt       = cell_alarm[0];
            cur_valid_nxt = 1'b1;
            count_nxt     = count_r - CNT_W'(1);
          end
        end else if (!cur_due) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          // fire; the word is last unless the next head is also due
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FIRE;
          out_alarm_nxt = cur_r;
          out_last_nxt  = (count_r == '0) || !head_due;
          cur_valid_nxt = 1'b0;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      count_r     <= '0;
      cur_valid_r <= 1'b0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      count_r     <= count_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
    is_tick_r   <= is_tick_nxt;
    new_r       <= new_nxt;
    out_kind_r  <= out_kind_nxt;
    out_alarm_r <= out_alarm_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.out_tag     = out_alarm_r.tag;
  assign out_ch.out_delay   = out_alarm_r.delay;
  assign out_ch.out_expiry  = out_alarm_r.expiry;
  assign out_ch.last_result = out_last_r;

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for sorted_alarm_timer_queue
// Drives insert and tick words over the command channel, predicts every
// result word with a behavioral copy of the alarm queue and compares each
// result word, in order, field by field.
// ---------------------------------------------------------------------------

module tb_top;
  import stq_pkg::*;

  localparam int   QDEPTH     = 16;
  localparam int   RAND_WORDS = 330;
  // worst tick plus margin: a pop and a fire per alarm (queue + current)
  localparam int   DRAIN_CYC  = 4 + 2 * (QDEPTH + 1) + 8;
  // ~354 words, each with up to 17 stalled results, fit well inside this limit
  localparam int   TIMEOUT_NS = 5_000_000;

  // one result word as the block reports it
  typedef struct packed {
    kind_t              kind;
    logic [TAG_W-1:0]   tag;
    logic [DELAY_W-1:0] delay;
    logic [TIME_W-1:0]  expiry;
    logic               last;
  } alarm_report_t;

  // directed stimulus row; typed rows carry their single expected word
  typedef struct {
    logic               cmd;
    logic [DELAY_W-1:0] delay;
    logic [TAG_W-1:0]   tag;
    bit                 typed;
    kind_t              kind;
    logic [TIME_W-1:0]  expiry;
  } dir_row_t;

  logic clk;
  logic rst_n;

  stq_in_if  in_ch ();
  stq_out_if out_ch ();

  sorted_alarm_timer_queue #(
    .QUEUE_DEPTH(QDEPTH)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // -------------------------------------------------------------------------
  // Alarm queue shadow: time, sorted pending alarms, the armed (popped) one
  // -------------------------------------------------------------------------
  logic [TIME_W-1:0] clock_now;
  alarm_t            pend_alarm [QDEPTH];
  int                pend_fill;
  bit                armed_valid;
  alarm_t            armed_alarm;

  alarm_report_t     step_reports [$];     // words caused by the last command
  alarm_report_t     awaited_reports [$];  // words the block still owes us

  int error_count    = 0;
  int words_sent     = 0;
  int ticks_sent     = 0;
  int n_accept       = 0;
  int n_reject       = 0;
  int n_fire         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  dir_row_t dir_rows [$];

  // serial time: a at or before b when (b - a) has its sign bit clear
  function automatic bit due_by(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] gap;
    gap = b - a;
    return !gap[TIME_W-1];
  endfunction

  // apply one accepted command word to the shadow, fill step_reports
  task automatic predict_alarms(input logic c, input logic [DELAY_W-1:0] d,
                                input logic [TAG_W-1:0] t);
    logic [TIME_W-1:0] ex;
    alarm_report_t     rpt;
    int                pos;
    int                i;
    bit                busy;
    step_reports.delete();
    if (c == CMD_INSERT) begin
      ex = clock_now + {{(TIME_W-DELAY_W){1'b0}}, d};
      if (pend_fill >= QDEPTH) begin
        // full: report what it would have been, state untouched
        rpt = '{kind: KIND_REJECT, tag: t, delay: d, expiry: ex, last: 1'b1};
      end else begin
        // new alarm goes ahead of the first entry expiring at or after it
        pos = pend_fill;
        for (i = 0; i < pend_fill; i++) begin
          if (pos == pend_fill && due_by(ex, pend_alarm[i].expiry)) pos = i;
        end
        for (i = pend_fill; i > pos; i--) pend_alarm[i] = pend_alarm[i-1];
        pend_alarm[pos] = '{expiry: ex, delay: d, tag: t};
        pend_fill++;
        rpt = '{kind: KIND_ACCEPT, tag: t, delay: d, expiry: ex, last: 1'b1};
      end
      step_reports.push_back(rpt);
    end else begin
      clock_now = clock_now + 32'd1;
      busy = 1'b1;
      while (busy) begin
        if (!armed_valid) begin
          if (pend_fill == 0) begin
            busy = 1'b0;
          end else begin
            armed_alarm = pend_alarm[0];
            for (i = 1; i < pend_fill; i++) pend_alarm[i-1] = pend_alarm[i];
            pend_fill--;
            armed_valid = 1'b1;
          end
        end
        if (busy) begin
          // armed alarm is never preempted; only its own expiry matters
          if (due_by(armed_alarm.expiry, clock_now)) begin
            rpt = '{kind: KIND_FIRE, tag: armed_alarm.tag, delay: armed_alarm.delay,
                    expiry: armed_alarm.expiry, last: 1'b0};
            step_reports.push_back(rpt);
            armed_valid = 1'b0;
          end else begin
            busy = 1'b0;
          end
        end
      end
      if (step_reports.size() > 0) begin
        rpt = step_reports[step_reports.size()-1];
        rpt.last = 1'b1;
        step_reports[step_reports.size()-1] = rpt;
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // -------------------------------------------------------------------------
  // Command side: optional idle gap, hold the word until ready, then predict.
  // valid is left high between back-to-back words (one NBA per edge).
  // -------------------------------------------------------------------------
  task automatic send_word(input logic c, input logic [DELAY_W-1:0] d,
                           input logic [TAG_W-1:0] t, input bit use_typed,
                           input alarm_report_t typed_rpt);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= c;
    in_ch.delay_seconds <= d;
    in_ch.tag_id        <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // word taken at this edge; results cannot show up before the next one
    predict_alarms(c, d, t);
    if (use_typed) awaited_reports.push_back(typed_rpt);
    else foreach (step_reports[k]) awaited_reports.push_back(step_reports[k]);
    words_sent++;
    if (c == CMD_TICK) ticks_sent++;
  endtask

  function automatic dir_row_t mk_row(input logic c, input logic [DELAY_W-1:0] d,
                                      input logic [TAG_W-1:0] t, input bit typed,
                                      input kind_t k, input logic [TIME_W-1:0] ex);
    dir_row_t r;
    r.cmd = c; r.delay = d; r.tag = t; r.typed = typed; r.kind = k; r.expiry = ex;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Clock
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Result side: random back-pressure per the current phase
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare every accepted result word against the oldest expectation
  always @(posedge clk) begin : watch_results
    alarm_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (out_ch.kind == KIND_ACCEPT) n_accept++;
      else if (out_ch.kind == KIND_REJECT) n_reject++;
      else n_fire++;
      if (awaited_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected result word kind=%0d tag=%h",
                                  out_ch.kind, out_ch.out_tag));
      end else begin
        want = awaited_reports.pop_front();
        if (out_ch.kind !== want.kind)
          report_mismatch($sformatf("kind got %0d want %0d", out_ch.kind, want.kind));
        if (out_ch.out_tag !== want.tag)
          report_mismatch($sformatf("tag got %h want %h", out_ch.out_tag, want.tag));
        if (out_ch.out_delay !== want.delay)
          report_mismatch($sformatf("delay got %h want %h (tag %h)",
                                    out_ch.out_delay, want.delay, want.tag));
        if (out_ch.out_expiry !== want.expiry)
          report_mismatch($sformatf("expiry got %h want %h (tag %h)",
                                    out_ch.out_expiry, want.expiry, want.tag));
        if (out_ch.last_result !== want.last)
          report_mismatch($sformatf("last got %b want %b (tag %h)",
                                    out_ch.last_result, want.last, want.tag));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    alarm_report_t      typed_rpt;
    logic               c;
    logic [DELAY_W-1:0] d;
    logic [TAG_W-1:0]   t;
    int                 insert_pct;
    int                 n;

    // shadow starts in its reset state
    clock_now   = '0;
    pend_fill   = 0;
    armed_valid = 1'b0;
    armed_alarm = '0;

    in_ch.valid         = 1'b0;
    in_ch.cmd           = CMD_INSERT;
    in_ch.delay_seconds = '0;
    in_ch.tag_id        = '0;
    rst_n               = 1'b0;

    // Directed rows. Time starts at 0; the comments track it.
    // zero delay right after reset: expires at time 0, fires on first tick
    dir_rows.push_back(mk_row(CMD_INSERT, 16'h0000, 16'h0000, 1, KIND_ACCEPT, 32'h0));
    dir_rows.push_back(mk_row(CMD_TICK, 16'h0000, 16'h0000, 0, KIND_FIRE, '0));  // now 1
    // nothing pending: no result at all
    dir_rows.push_back(mk_row(CMD_TICK, 16'hFFFF, 16'hFFFF, 0, KIND_FIRE, '0));  // now 2
    // three alarms sharing one expiry: later inserts go ahead, fire A003 first
    for (int k = 1; k <= 3; k++)
      dir_rows.push_back(mk_row(CMD_INSERT, 16'd3, 16'hA000 + k[15:0], 0, KIND_ACCEPT, '0));
    // thirteen more at an earlier shared expiry fill the queue to 16
    for (int k = 0; k < 13; k++)
      dir_rows.push_back(mk_row(CMD_INSERT, 16'd1, 16'hB000 + k[15:0], 0, KIND_ACCEPT, '0));
    // full queue: rejected with the expiry it would have had (2 + FFFF)
    dir_rows.push_back(mk_row(CMD_INSERT, 16'hFFFF, 16'hFFFF, 1, KIND_REJECT, 32'h0001_0001));
    // now 3: all thirteen fire in one tick, then A003 is armed but not due
    dir_rows.push_back(mk_row(CMD_TICK, 16'h0000, 16'h0000, 0, KIND_FIRE, '0));
    dir_rows.push_back(mk_row(CMD_TICK, 16'h0000, 16'h0000, 0, KIND_FIRE, '0));  // now 4
    // earlier expiry than the armed alarm: must not preempt it
    dir_rows.push_back(mk_row(CMD_INSERT, 16'h0000, 16'h5A5A, 0, KIND_ACCEPT, '0));
    // now 5: A003, then 5A5A, A002, A001 in one tick
    dir_rows.push_back(mk_row(CMD_TICK, 16'h0000, 16'h0000, 0, KIND_FIRE, '0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed part runs with both sides always ready
    foreach (dir_rows[r]) begin
      typed_rpt = '{kind: dir_rows[r].kind, tag: dir_rows[r].tag,
                    delay: dir_rows[r].delay, expiry: dir_rows[r].expiry, last: 1'b1};
      send_word(dir_rows[r].cmd, dir_rows[r].delay, dir_rows[r].tag,
                dir_rows[r].typed, typed_rpt);
    end

    // Random part in four idling phases: none, sender gaps, receiver stalls,
    // light on both. The insert/tick mix changes every 20 words so the queue
    // both drains to empty and runs full.
    insert_pct = 55;
    typed_rpt  = '0;
    for (n = 0; n < RAND_WORDS; n++) begin
      case (n * 4 / RAND_WORDS)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
      endcase
      if (n % 20 == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 30;
          1:       insert_pct = 55;
          default: insert_pct = 80;
        endcase
      end
      t = 16'($urandom);
      if ($urandom_range(99) < insert_pct) begin
        c = CMD_INSERT;
        // full queue rejects, so any delay is harmless there; otherwise keep
        // delays short so armed alarms do not park the queue for long
        if (pend_fill >= QDEPTH) d = 16'($urandom);
        else if ($urandom_range(99) < 85) d = 16'($urandom_range(6));
        else d = 16'($urandom_range(40));
      end else begin
        c = CMD_TICK;
        d = 16'($urandom);   // ignored on ticks
      end
      send_word(c, d, t, 1'b0, typed_rpt);
    end

    in_ch.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    // catch any stray word after the last expected one
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d command words (%0d inserts, %0d ticks), alarm time reached %0d.",
             words_sent, words_sent - ticks_sent, ticks_sent, clock_now);
    $display("Checked results: %0d accepted, %0d rejected full, %0d fired; %0d mismatches.",
             n_accept, n_reject, n_fire, error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // Watchdog
  // -------------------------------------------------------------------------
  initial begin
    #(TIMEOUT_NS);
    $display("Watchdog expired with %0d result words outstanding", awaited_reports.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
rtl/stq_pkg.sv
rtl/stq_ifs.sv
rtl/stq_cell.sv
rtl/sorted_alarm_timer_queue.sv
sim/tb_top.sv
